/* rtl/core/fifo_with_overflow_policy_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO with overflow policy
// Shared property forms, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_OVERFLOW_POLICY_CORE_ASSERT_SVH
`define FIFO_WITH_OVERFLOW_POLICY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FWOP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fwop assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FWOP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fwop assertion failed");

`endif

/* rtl/core/fwop_pkg.sv */
// ----------------------------------------------------------------------------
// fwop_pkg
// Types, constants and codes shared by the FIFO with overflow policy.
// ----------------------------------------------------------------------------
package fwop_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAMP_W = 64;
  localparam int unsigned SEQ_W   = 64;
  localparam int unsigned CNT_W   = 64;
  localparam int unsigned PEND_W  = 5;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLOSE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    POL_REJECT_NEW  = 2'd0,
    POL_DROP_NEWEST = 2'd1,
    POL_DROP_OLDEST = 2'd2,
    POL_KEEP_LATEST = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DROPPED = 3'd2,
    ST_CLOSED  = 3'd3,
    ST_AGAIN   = 3'd4,
    ST_END     = 3'd5
  } status_e;

  localparam logic [PADDR_W-1:0] REG_POLICY = '0;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq;
    logic [STAMP_W-1:0] stamp;
    logic [DATA_W-1:0]  data;
  } record_t;

  typedef struct packed {
    logic             en;
    logic             we;
    logic [PTR_W-1:0] addr;
    record_t          wdata;
  } ram_cmd_t;

  typedef struct packed {
    status_e           status;
    logic              pop_ok;
    logic [CNT_W-1:0]  dropped;
    logic [FILL_W-1:0] fill;
  } meta_t;

endpackage

/* rtl/core/fwop_if.sv */
// ----------------------------------------------------------------------------
// fwop_in_if / fwop_out_if
// Valid-ready channels carrying operations into and results out of the FIFO.
// ----------------------------------------------------------------------------
interface fwop_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] data_in;
  logic [63:0] timestamp_in;

  modport source (output valid, mode, data_in, timestamp_in, input ready);
  modport sink (input valid, mode, data_in, timestamp_in, output ready);
endinterface

interface fwop_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] data_out;
  logic [63:0] timestamp_out;
  logic [63:0] sequence_out;
  logic [63:0] dropped_count;
  logic [4:0]  pending_count;

  modport source (output valid, status, data_out, timestamp_out, sequence_out,
                  dropped_count, pending_count, input ready);
  modport sink (input valid, status, data_out, timestamp_out, sequence_out,
                dropped_count, pending_count, output ready);
endinterface

/* rtl/core/fwop_ram.sv */
// ----------------------------------------------------------------------------
// fwop_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module fwop_ram #(
  parameter int unsigned WIDTH  = 160,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/fwop_ctrl.sv */
// ----------------------------------------------------------------------------
// fwop_ctrl
// Pointer, fill, sequence and drop bookkeeping; issues the record store access.
// ----------------------------------------------------------------------------
module fwop_ctrl
  import fwop_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          mode_i,
  input  logic [DATA_W-1:0]   data_i,
  input  logic [STAMP_W-1:0]  stamp_i,
  input  policy_e             policy_i,
  output ram_cmd_t            ram_cmd_o,
  output meta_t               meta_o
);

  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [CNT_W-1:0]  drop_q, drop_d;
  logic              closed_q, closed_d;

  logic              clr;
  logic              full;
  logic [FILL_W-1:0] fill_mid;
  logic [PTR_W-1:0]  head_mid;
  logic [FILL_W-1:0] drop_inc;

  function automatic logic [PTR_W-1:0] advance(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    fill_d   = fill_q;
    seq_d    = seq_q;
    closed_d = closed_q;
    drop_inc = '0;

    clr      = (policy_i == POL_KEEP_LATEST) && (fill_q != '0);
    fill_mid = clr ? '0 : fill_q;
    head_mid = clr ? tail_q : head_q;
    full     = (fill_mid == FILL_W'(DEPTH));

    ram_cmd_o.en         = 1'b0;
    ram_cmd_o.we         = 1'b0;
    ram_cmd_o.addr       = head_q;
    ram_cmd_o.wdata.seq  = seq_q;
    ram_cmd_o.wdata.stamp = stamp_i;
    ram_cmd_o.wdata.data = data_i;

    meta_o.status = ST_OK;
    meta_o.pop_ok = 1'b0;

    unique case (mode_e'(mode_i))
      MODE_PUSH: begin
        if (closed_q) begin
          meta_o.status = ST_CLOSED;
        end else if (full && (policy_i == POL_REJECT_NEW)) begin
          meta_o.status = ST_FULL;
        end else if (full && (policy_i == POL_DROP_NEWEST)) begin
          meta_o.status = ST_DROPPED;
          drop_inc      = FILL_W'(1);
        end else begin
          head_d = head_mid;
          fill_d = fill_mid;
          if (clr) begin
            drop_inc = fill_q;
          end
          if (full) begin
            head_d   = advance(head_mid);
            fill_d   = fill_mid - 1'b1;
            drop_inc = FILL_W'(1);
          end
          ram_cmd_o.en   = accept_i;
          ram_cmd_o.we   = 1'b1;
          ram_cmd_o.addr = tail_q;
          tail_d         = advance(tail_q);
          fill_d         = fill_d + 1'b1;
          seq_d          = seq_q + 1'b1;
          meta_o.status  = (clr || full) ? ST_DROPPED : ST_OK;
        end
      end
      MODE_POP: begin
        if (fill_q == '0) begin
          meta_o.status = closed_q ? ST_END : ST_AGAIN;
        end else begin
          ram_cmd_o.en  = accept_i;
          head_d        = advance(head_q);
          fill_d        = fill_q - 1'b1;
          meta_o.pop_ok = 1'b1;
        end
      end
      MODE_CLOSE: begin
        closed_d = 1'b1;
      end
      default: begin
      end
    endcase

    drop_d         = drop_q + CNT_W'(drop_inc);
    meta_o.dropped = drop_d;
    meta_o.fill    = fill_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      fill_q   <= '0;
      seq_q    <= '0;
      drop_q   <= '0;
      closed_q <= 1'b0;
    end else if (accept_i) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      fill_q   <= fill_d;
      seq_q    <= seq_d;
      drop_q   <= drop_d;
      closed_q <= closed_d;
    end
  end

endmodule

/* rtl/core/fifo_with_overflow_policy_core.sv */
// ----------------------------------------------------------------------------
// fifo_with_overflow_policy_core
// FIFO of timestamped, sequence-numbered records with an overflow policy.
// ----------------------------------------------------------------------------
// Operations arrive on the in_if channel (push, pop or close) and each one
// produces exactly one result transfer on out_if, in order. The overflow
// policy register sits at APB byte address 0; the user must write it only
// while idle (the block does not enforce this). An operation is decoded in
// the cycle it is accepted: pointers and counters update at once, and the
// record store is written for a push or read for a pop. The store has one
// port with a registered read; a result waits in the decode stage (meta_q
// and the read register) until the output register is free, then leaves
// when the receiver takes it. While the receiver takes results, one
// operation is accepted every cycle; the single store port sets that figure.
// When the receiver stalls, at most one further operation is accepted and
// waits in the decode stage, then in_if.ready drops until the output
// register frees. Reset empties the FIFO, opens the input and clears the
// sequence and drop counters; store contents are not cleared by any pass.
// ----------------------------------------------------------------------------
module fifo_with_overflow_policy_core
  import fwop_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  fwop_in_if.sink            in_if,
  fwop_out_if.source         out_if
);

  `include "fifo_with_overflow_policy_core_assert.svh"

  policy_e  policy_q;
  logic     accept;
  logic     load;
  logic     pend_q;
  meta_t    meta;
  meta_t    meta_q;
  ram_cmd_t ram_cmd;
  record_t  rdata;
  logic     out_valid_q;
  meta_t    out_meta_q;
  record_t  out_rec_q;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_POLICY) ? PDATA_W'(policy_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_REJECT_NEW;
    end else if (psel && penable && pwrite && (paddr == REG_POLICY)) begin
      policy_q <= policy_e'(pwdata[1:0]);
    end
  end

  assign load        = pend_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !pend_q || load;
  assign accept      = in_if.valid && in_if.ready;

  fwop_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .mode_i   (in_if.mode),
    .data_i   (in_if.data_in),
    .stamp_i  (in_if.timestamp_in),
    .policy_i (policy_q),
    .ram_cmd_o(ram_cmd),
    .meta_o   (meta)
  );

  fwop_ram #(
    .WIDTH($bits(record_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_cmd.en),
    .we_i   (ram_cmd.we),
    .addr_i (ram_cmd.addr),
    .wdata_i(ram_cmd.wdata),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (accept) begin
      pend_q <= 1'b1;
    end else if (load) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= meta;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_meta_q <= meta_q;
      out_rec_q  <= meta_q.pop_ok ? rdata : '0;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = out_meta_q.status;
  assign out_if.data_out      = out_rec_q.data;
  assign out_if.timestamp_out = out_rec_q.stamp;
  assign out_if.sequence_out  = out_rec_q.seq;
  assign out_if.dropped_count = out_meta_q.dropped;
  assign out_if.pending_count = PEND_W'(out_meta_q.fill);

  `FWOP_ASSERT_NEXT(a_accept_pends, accept, pend_q)
  `FWOP_ASSERT_NEXT(a_stall_holds, pend_q && out_valid_q && !out_if.ready, pend_q)
  `FWOP_ASSERT_SAME(a_empty_status,
    out_if.valid && (out_if.status == ST_AGAIN || out_if.status == ST_END),
    out_if.pending_count == '0)
  `FWOP_ASSERT_SAME(a_full_status, out_if.valid && (out_if.status == ST_FULL),
    out_if.pending_count == PEND_W'(DEPTH))

endmodule

/* tb/fifo_with_overflow_policy_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_overflow_policy_core_tb
// Self-checking testbench for the FIFO with overflow policy. Push, pop and
// no-op operations are sent under every overflow policy, close under drop-newest. Each operation is
// run through a behavioural FIFO model when its transfer is accepted, and every
// result transfer is compared field by field with the oldest predicted result.
// Both channels idle at random, and one long receiver hold-off fills the block.
// ----------------------------------------------------------------------------
module fifo_with_overflow_policy_core_tb;
  import fwop_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  data;
    logic [STAMP_W-1:0] stamp;
    logic [SEQ_W-1:0]   seq;
    logic [CNT_W-1:0]   dropped;
    logic [PEND_W-1:0]  pending;
  } op_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fwop_in_if  in_if ();
  fwop_out_if out_if ();

  fifo_with_overflow_policy_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_if   (in_if),
    .out_if  (out_if)
  );

  // Behavioural copy of the FIFO state.
  policy_e            m_policy;
  logic [DATA_W-1:0]  m_payload [DEPTH];
  logic [STAMP_W-1:0] m_stamp [DEPTH];
  logic [SEQ_W-1:0]   m_seq [DEPTH];
  logic [PTR_W-1:0]   m_head;
  logic [PTR_W-1:0]   m_tail;
  logic [FILL_W-1:0]  m_fill;
  logic [SEQ_W-1:0]   m_seq_next;
  logic [CNT_W-1:0]   m_drops;
  bit                 m_closed;

  op_result_t  op_result_q[$];
  int unsigned err_count;
  int unsigned tx_max_gap;
  int unsigned tx_burst_left;
  int unsigned rx_max_stall;
  int unsigned rx_hold_len;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [PTR_W-1:0] fifo_next_ptr(logic [PTR_W-1:0] p);
    return (int'(p) + 1 >= DEPTH) ? '0 : p + 1'b1;
  endfunction

  function automatic op_result_t apply_fifo_op(logic [1:0] op, logic [DATA_W-1:0] din,
                                               logic [STAMP_W-1:0] tin);
    op_result_t r;
    bit dropped;
    bit store;
    r = '0;
    r.status = ST_OK;
    dropped = 1'b0;
    store = 1'b1;
    case (op)
      MODE_PUSH: begin
        if (m_closed) begin
          r.status = ST_CLOSED;
        end else begin
          if (m_policy == POL_KEEP_LATEST && m_fill != 0) begin
            m_drops += CNT_W'(m_fill);
            m_fill = '0;
            m_head = m_tail;
            dropped = 1'b1;
          end
          if (m_fill >= DEPTH) begin
            if (m_policy == POL_REJECT_NEW) begin
              r.status = ST_FULL;
              store = 1'b0;
            end else if (m_policy == POL_DROP_NEWEST) begin
              m_drops++;
              r.status = ST_DROPPED;
              store = 1'b0;
            end else begin
              m_head = fifo_next_ptr(m_head);
              m_fill--;
              m_drops++;
              dropped = 1'b1;
            end
          end
          if (store) begin
            m_payload[m_tail] = din;
            m_stamp[m_tail] = tin;
            m_seq[m_tail] = m_seq_next;
            m_seq_next++;
            m_tail = fifo_next_ptr(m_tail);
            m_fill++;
            r.status = dropped ? ST_DROPPED : ST_OK;
          end
        end
      end
      MODE_POP: begin
        if (m_fill == 0) begin
          r.status = m_closed ? ST_END : ST_AGAIN;
        end else begin
          r.data = m_payload[m_head];
          r.stamp = m_stamp[m_head];
          r.seq = m_seq[m_head];
          m_head = fifo_next_ptr(m_head);
          m_fill--;
        end
      end
      MODE_CLOSE: m_closed = 1'b1;
      default: ;
    endcase
    r.dropped = m_drops;
    r.pending = PEND_W'(m_fill);
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    op_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (op_result_q.size() == 0) begin
        $error("result transfer with nothing pending, status %0d", out_if.status);
        err_count++;
      end else begin
        want = op_result_q.pop_front();
        check_field("status", 64'(want.status), 64'(out_if.status));
        check_field("data_out", 64'(want.data), 64'(out_if.data_out));
        check_field("timestamp_out", want.stamp, out_if.timestamp_out);
        check_field("sequence_out", want.seq, out_if.sequence_out);
        check_field("dropped_count", want.dropped, out_if.dropped_count);
        check_field("pending_count", 64'(want.pending), 64'(out_if.pending_count));
      end
    end
  end

  // The receiver alternates ready and stalled stretches; a hold-off request
  // in rx_hold_len overrides the pattern and holds ready low until it runs out.
  initial begin
    int unsigned run;
    bit on;
    out_if.ready = 1'b0;
    run = 0;
    on = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        rx_hold_len--;
        out_if.ready <= 1'b0;
      end else begin
        if (run == 0) begin
          on = !on || (rx_max_stall == 0);
          run = on ? $urandom_range(12, 1) : $urandom_range(rx_max_stall, 1);
        end
        run--;
        out_if.ready <= on;
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [STAMP_W-1:0] rand_stamp();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic issue_op(input logic [1:0] op, input logic [DATA_W-1:0] din,
                          input logic [STAMP_W-1:0] tin);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      gap = (tx_max_gap == 0) ? 0 : $urandom_range(tx_max_gap, 0);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      tx_burst_left = $urandom_range(16, 1);
    end
    tx_burst_left--;
    in_if.valid <= 1'b1;
    in_if.mode <= op;
    in_if.data_in <= din;
    in_if.timestamp_in <= tin;
    do @(posedge clk_i); while (!in_if.ready);
    op_result_q.push_back(apply_fifo_op(op, din, tin));
    @(negedge clk_i);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (op_result_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_policy(input policy_e pol);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_POLICY;
    pwdata <= PDATA_W'(pol);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    m_policy = pol;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(pol)) begin
      $error("overflow_policy readback mismatch: expected 0x%0h, got 0x%0h",
             PDATA_W'(pol), prdata);
      err_count++;
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Segments favour pushes, pops or neither, so that the fill level swings
  // between empty and full.
  task automatic run_random_ops(input int unsigned count, input bit with_close);
    int unsigned seg_left;
    int unsigned push_pct;
    int unsigned roll;
    logic [1:0] op;
    seg_left = 0;
    push_pct = 50;
    repeat (count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(50, 10);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      seg_left--;
      roll = $urandom_range(99);
      if (roll < 3) op = MODE_NOP;
      else if (with_close && roll < 6) op = MODE_CLOSE;
      else if (roll < push_pct) op = MODE_PUSH;
      else op = MODE_POP;
      issue_op(op, rand_data(), rand_stamp());
    end
  endtask

  task automatic test_basic_ops();
    tx_max_gap = 2;
    rx_max_stall = 2;
    issue_op(MODE_POP, '1, '1);
    issue_op(MODE_PUSH, '0, '0);
    issue_op(MODE_PUSH, '1, '1);
    issue_op(MODE_PUSH, 32'hA5C3_5A3C, 64'h0123_4567_89AB_CDEF);
    issue_op(MODE_NOP, '1, '1);
    issue_op(MODE_POP, '0, '0);
    issue_op(MODE_POP, '0, '0);
    issue_op(MODE_NOP, '0, '0);
    issue_op(MODE_POP, '0, '0);
    issue_op(MODE_POP, '0, '0);
    wait_drain();
  endtask

  task automatic test_policy_sweep();
    policy_e plan [6];
    plan = '{POL_REJECT_NEW, POL_DROP_NEWEST, POL_DROP_OLDEST, POL_KEEP_LATEST,
             policy_e'($urandom_range(3)), policy_e'($urandom_range(3))};
    for (int i = 0; i < 6; i++) begin
      set_policy(plan[i]);
      tx_max_gap = (i % 3 == 0) ? 0 : $urandom_range(10, 2);
      rx_max_stall = (i % 2 == 0) ? $urandom_range(8, 1) : 0;
      run_random_ops(260, 1'b0);
      wait_drain();
    end
  endtask

  // The receiver holds off while pushes keep coming, so the block fills its
  // pipeline and lowers its input ready.
  task automatic test_backpressure_fill();
    set_policy(POL_DROP_OLDEST);
    tx_max_gap = 0;
    rx_max_stall = 3;
    rx_hold_len = 120;
    repeat (40) issue_op(MODE_PUSH, rand_data(), rand_stamp());
    wait_drain();
  endtask

  task automatic test_close_input();
    set_policy(POL_DROP_NEWEST);
    tx_max_gap = 3;
    rx_max_stall = 3;
    repeat (20) issue_op(MODE_PUSH, rand_data(), rand_stamp());
    issue_op(MODE_CLOSE, rand_data(), rand_stamp());
    issue_op(MODE_CLOSE, rand_data(), rand_stamp());
    issue_op(MODE_PUSH, '1, '1);
    run_random_ops(60, 1'b1);
    repeat (3) issue_op(MODE_POP, '0, '0);
    wait_drain();
  endtask

  initial begin
    m_policy = POL_REJECT_NEW;
    m_head = '0;
    m_tail = '0;
    m_fill = '0;
    m_seq_next = '0;
    m_drops = '0;
    m_closed = 1'b0;
    err_count = 0;
    tx_max_gap = 0;
    tx_burst_left = 0;
    rx_max_stall = 0;
    rx_hold_len = 0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_PUSH;
    in_if.data_in = '0;
    in_if.timestamp_in = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_ops();
    test_policy_sweep();
    test_backpressure_fill();
    test_close_input();

    repeat (8) @(negedge clk_i);
    if (op_result_q.size() != 0) begin
      $error("%0d predicted results never arrived", op_result_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/fwop_pkg.sv
rtl/core/fwop_if.sv
rtl/core/fwop_ram.sv
rtl/core/fwop_ctrl.sv
rtl/core/fifo_with_overflow_policy_core.sv
tb/fifo_with_overflow_policy_core_tb.sv
